### hdl/ctg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctg_pkg
// Shared types, codes and reset values for the compressor thermostat guard.
// ----------------------------------------------------------------------------
package ctg_pkg;

   localparam int TEMP_BITS_DEF  = 12;
   localparam int TIMER_BITS_DEF = 32;

   localparam int SETPOINT_BITS = 11;
   localparam int BAND_BITS     = 8;
   localparam int TIMEOUT_BITS  = 24;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = TIMEOUT_BITS;
   localparam int OP_BITS       = 3;
   localparam int ACTION_BITS   = 2;

   localparam logic [SETPOINT_BITS-1:0] SETPOINT_RST   = 11'd990;
   localparam logic [BAND_BITS-1:0]     UPPER_BAND_RST = 8'd15;
   localparam logic [BAND_BITS-1:0]     LOWER_BAND_RST = 8'd8;
   localparam logic [BAND_BITS-1:0]     MIN_DROP_RST   = 8'd4;
   localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RST    = 24'd600000;

   typedef enum logic [OP_BITS-1:0] {
      OP_TICK   = 3'd0,
      OP_CHECK  = 3'd1,
      OP_START  = 3'd2,
      OP_STOP   = 3'd3,
      OP_BYPASS = 3'd4
   } ctg_op_type;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_NONE        = 2'd0,
      ACT_STARTED     = 2'd1,
      ACT_STOP_NOCOOL = 2'd2,
      ACT_STOP_TARGET = 2'd3
   } ctg_action_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_SETPOINT   = 3'd0,
      CSR_UPPER_BAND = 3'd1,
      CSR_LOWER_BAND = 3'd2,
      CSR_MIN_DROP   = 3'd3,
      CSR_TIMEOUT    = 3'd4
   } ctg_csr_type;

   typedef struct packed {
      logic [SETPOINT_BITS-1:0] setpoint;
      logic [BAND_BITS-1:0]     upper_band;
      logic [BAND_BITS-1:0]     lower_band;
      logic [BAND_BITS-1:0]     min_drop;
      logic [TIMEOUT_BITS-1:0]  switch_timeout;
   } ctg_cfg_type;

   typedef struct packed {
      logic unit_on;
      logic running;
      logic start_valid;
      logic bypass;
   } ctg_flags_type;

endpackage

### hdl/ctg_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctg_decide
// Next-state and action logic for one item: tick, check, start, stop, bypass.
// ----------------------------------------------------------------------------
module ctg_decide import ctg_pkg::*; #(
   parameter int TEMP_BITS  = TEMP_BITS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic [OP_BITS-1:0]    op,
   input  logic [TEMP_BITS-1:0]  room,
   input  logic                  bypass_flag,
   input  ctg_cfg_type           cfg,
   input  ctg_flags_type         flags_cur,
   input  logic [TIMER_BITS-1:0] since_cur,
   input  logic [TEMP_BITS-1:0]  start_cur,
   output ctg_flags_type         flags_nxt,
   output logic [TIMER_BITS-1:0] since_nxt,
   output logic [TEMP_BITS-1:0]  start_nxt,
   output ctg_action_type        action
);

   // signed compare width: covers the temperature, setpoint plus band, and one sign bit
   localparam int BASE_BITS = (TEMP_BITS > SETPOINT_BITS + 1) ? TEMP_BITS : SETPOINT_BITS + 1;
   localparam int CW        = BASE_BITS + 2;
   localparam int T4_BITS   = TIMEOUT_BITS + 2;

   logic signed [CW-1:0] room_ext;
   logic signed [CW-1:0] start_ext;
   logic signed [CW-1:0] hi_lim;
   logic signed [CW-1:0] lo_lim;
   logic signed [CW-1:0] drop;
   logic signed [CW-1:0] min_drop_ext;
   logic [T4_BITS-1:0]     thr_x4;
   logic [TIMEOUT_BITS:0]  half_sum;
   logic [TIMEOUT_BITS-1:0] thr_half;
   logic                  over_x4;
   logic                  over_x1;
   logic                  over_half;
   logic                  rule_nocool;
   logic                  rule_start;
   logic                  rule_target;

   assign room_ext     = {{(CW-TEMP_BITS){room[TEMP_BITS-1]}}, room};
   assign start_ext    = {{(CW-TEMP_BITS){start_cur[TEMP_BITS-1]}}, start_cur};
   assign hi_lim       = {{(CW-SETPOINT_BITS){1'b0}}, cfg.setpoint}
                       + {{(CW-BAND_BITS){1'b0}}, cfg.upper_band};
   assign lo_lim       = {{(CW-SETPOINT_BITS){1'b0}}, cfg.setpoint}
                       - {{(CW-BAND_BITS){1'b0}}, cfg.lower_band};
   assign drop         = start_ext - room_ext;
   assign min_drop_ext = {{(CW-BAND_BITS){1'b0}}, cfg.min_drop};

   assign thr_x4   = {cfg.switch_timeout, 2'b00};
   assign half_sum = {1'b0, cfg.switch_timeout} + {{TIMEOUT_BITS{1'b0}}, 1'b1};
   assign thr_half = half_sum[TIMEOUT_BITS:1];

   assign over_x4   = flags_cur.bypass
                    || (since_cur > {{(TIMER_BITS-T4_BITS){1'b0}}, thr_x4});
   assign over_x1   = flags_cur.bypass
                    || (since_cur > {{(TIMER_BITS-TIMEOUT_BITS){1'b0}}, cfg.switch_timeout});
   assign over_half = flags_cur.bypass
                    || (since_cur > {{(TIMER_BITS-TIMEOUT_BITS){1'b0}}, thr_half});

   assign rule_nocool = flags_cur.running && flags_cur.start_valid && over_x4
                      && (drop < min_drop_ext);
   assign rule_start  = !flags_cur.running && (room_ext > hi_lim) && over_x1;
   assign rule_target = flags_cur.running && (room_ext <= lo_lim) && over_half;

   always_comb begin
      flags_nxt = flags_cur;
      since_nxt = since_cur;
      start_nxt = start_cur;
      action    = ACT_NONE;
      case (ctg_op_type'(op))
         OP_TICK: begin
            // hold at all ones instead of wrapping
            if (since_cur != {TIMER_BITS{1'b1}}) begin
               since_nxt = since_cur + {{(TIMER_BITS-1){1'b0}}, 1'b1};
            end
         end
         OP_CHECK: begin
            if (flags_cur.unit_on) begin
               if (rule_nocool) begin
                  flags_nxt.running     = 1'b0;
                  flags_nxt.start_valid = 1'b0;
                  flags_nxt.bypass      = 1'b0;
                  since_nxt             = '0;
                  action                = ACT_STOP_NOCOOL;
               end else if (rule_start) begin
                  flags_nxt.running     = 1'b1;
                  flags_nxt.start_valid = 1'b1;
                  flags_nxt.bypass      = 1'b0;
                  since_nxt             = '0;
                  start_nxt             = room;
                  action                = ACT_STARTED;
               end else if (rule_target) begin
                  flags_nxt.running     = 1'b0;
                  flags_nxt.start_valid = 1'b0;
                  flags_nxt.bypass      = 1'b0;
                  since_nxt             = '0;
                  action                = ACT_STOP_TARGET;
               end
            end
         end
         OP_START: begin
            flags_nxt.unit_on = 1'b1;
            since_nxt         = '0;
         end
         OP_STOP: begin
            flags_nxt.unit_on = 1'b0;
            flags_nxt.running = 1'b0;
            since_nxt         = '0;
         end
         OP_BYPASS: begin
            flags_nxt.bypass = bypass_flag;
         end
         default: begin
         end
      endcase
   end

endmodule

### hdl/compressor_thermostat_guard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compressor_thermostat_guard
// Hysteresis compressor control with anti-short-cycle timing.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transfer: tuser is the opcode (tick, check,
//   start, stop, set bypass), tdata holds the room temperature and the new
//   bypass flag. Every command yields exactly one rsp_* transfer with the
//   compressor and fan drives after the command and the action taken.
//   csr_* writes the setpoint, bands, minimum drop and switch timeout; write
//   only while no command is in flight.
//   A command accepted on req_* is captured in the input register, evaluated
//   against the state and registered onto rsp_* in the result register; while
//   the receiver stalls, the command waits in the input register. Throughput
//   is one command per cycle while the receiver keeps rsp_tready high, set by
//   the single evaluation stage between the input and the result register.
//   Reset clears all control state, loads the default configuration and
//   empties both registers. When the receiver stalls, the result register
//   holds; the input register takes one more command, then req_tready drops
//   until rsp_tready returns.
// ----------------------------------------------------------------------------
module compressor_thermostat_guard import ctg_pkg::*; #(
   parameter int TEMP_BITS  = TEMP_BITS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // opcode
   input  logic [OP_BITS-1:0]            req_tuser,
   // room_temp, bypass_flag, zero fill
   input  logic [((TEMP_BITS+8)/8)*8-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // compressor_on, fan_on, action[1:0], zero fill
   output logic [7:0]                    rsp_tdata,
   input  logic                          csr_we,
   input  logic [CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   ctg_cfg_type            cfg_ff, cfg_in;
   ctg_flags_type          flags_ff, flags_in;
   logic [TIMER_BITS-1:0]  since_ff, since_in;
   logic [TEMP_BITS-1:0]   start_ff, start_in;

   logic                   req_valid_ff;
   logic [OP_BITS-1:0]     req_op_ff;
   logic [TEMP_BITS-1:0]   req_room_ff;
   logic                   req_flag_ff;

   logic                   rsp_valid_ff;
   logic [7:0]             rsp_data_ff;

   ctg_action_type         action;
   logic                   advance;
   logic                   fire;
   logic                   req_xfer;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = req_valid_ff && advance;
   assign req_tready = !req_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ctg_decide #(
      .TEMP_BITS  (TEMP_BITS),
      .TIMER_BITS (TIMER_BITS)
   ) u_decide (
      .op          (req_op_ff),
      .room        (req_room_ff),
      .bypass_flag (req_flag_ff),
      .cfg         (cfg_ff),
      .flags_cur   (flags_ff),
      .since_cur   (since_ff),
      .start_cur   (start_ff),
      .flags_nxt   (flags_in),
      .since_nxt   (since_in),
      .start_nxt   (start_in),
      .action      (action)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (ctg_csr_type'(csr_addr))
            CSR_SETPOINT:   cfg_in.setpoint       = csr_wdata[SETPOINT_BITS-1:0];
            CSR_UPPER_BAND: cfg_in.upper_band     = csr_wdata[BAND_BITS-1:0];
            CSR_LOWER_BAND: cfg_in.lower_band     = csr_wdata[BAND_BITS-1:0];
            CSR_MIN_DROP:   cfg_in.min_drop       = csr_wdata[BAND_BITS-1:0];
            CSR_TIMEOUT:    cfg_in.switch_timeout = csr_wdata[TIMEOUT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{setpoint:       SETPOINT_RST,
                     upper_band:     UPPER_BAND_RST,
                     lower_band:     LOWER_BAND_RST,
                     min_drop:       MIN_DROP_RST,
                     switch_timeout: TIMEOUT_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // state advances only as an item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         since_ff <= '0;
         start_ff <= '0;
      end else if (fire) begin
         flags_ff <= flags_in;
         since_ff <= since_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         req_op_ff   <= req_tuser;
         req_room_ff <= req_tdata[TEMP_BITS-1:0];
         req_flag_ff <= req_tdata[TEMP_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {4'b0000, action, flags_in.unit_on, flags_in.running};
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_run_needs_unit: assert property (@(posedge clock) disable iff (reset)
      flags_ff.running |-> flags_ff.unit_on)
      else $error("compressor running while unit is off");

   a_switch_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && action != ACT_NONE) |=> (since_ff == '0 && !flags_ff.bypass))
      else $error("switch did not clear timer and bypass");

   a_stall_backs_up: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (req_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipeline");

   a_start_drives: assert property (@(posedge clock) disable iff (reset)
      (fire && action == ACT_STARTED) |=> (rsp_valid_ff && rsp_data_ff[0]))
      else $error("start action without compressor drive");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the compressor thermostat guard. A directed opening
// covers the off, bypass, start, stop and ineffective-cooling cases, then
// eight configuration phases run weighted random command streams. Every
// command is predicted at its req transfer and checked at its rsp transfer.
// ----------------------------------------------------------------------------
module testbench;
   import ctg_pkg::*;

   localparam int TEMP_W         = TEMP_BITS_DEF;
   localparam int TIMER_W        = TIMER_BITS_DEF;
   localparam int REQ_W          = ((TEMP_W + 8) / 8) * 8;
   localparam int TEMP_MIN       = -(1 << (TEMP_W - 1));
   localparam int TEMP_MAX       = (1 << (TEMP_W - 1)) - 1;
   localparam int PHASE_ITEMS    = 100;
   localparam int PHASES         = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [OP_BITS-1:0] OP_UNUSED_LO = OP_BITS'(OP_BYPASS + 1);
   localparam logic [OP_BITS-1:0] OP_UNUSED_HI = '1;

   typedef struct packed {
      logic [OP_BITS-1:0] op;
      logic [TEMP_W-1:0]  room;
      logic               flag;
   } guard_cmd_type;

   typedef struct packed {
      logic           compressor;
      logic           fan;
      ctg_action_type action;
   } guard_drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // opcode
   logic [OP_BITS-1:0]       req_tuser  = '0;
   // room_temp, bypass_flag, zero fill
   logic [REQ_W-1:0]         req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // compressor_on, fan_on, action[1:0], zero fill
   logic [7:0]               rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   // predictor copy of configuration and control state
   ctg_cfg_type              cfg;
   logic                     unit_on     = 1'b0;
   logic                     cmp_running = 1'b0;
   logic [TIMER_W-1:0]       since_ms    = '0;
   logic signed [TEMP_W-1:0] start_room  = '0;
   logic                     start_ok    = 1'b0;
   logic                     bypass_on   = 1'b0;

   guard_cmd_type   cmd_q[$];
   guard_drive_type drive_q[$];

   int unsigned req_gap      = 0;
   int unsigned rsp_gap      = 0;
   int unsigned mismatch_cnt = 0;
   int unsigned quiet_cycles = 0;
   logic        no_idle      = 1'b0;

   compressor_thermostat_guard u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic past_timeout(input logic [TIMER_W+1:0] limit);
      return bypass_on || ({2'b00, since_ms} > limit);
   endfunction

   function automatic guard_drive_type guard_decide(input guard_cmd_type c);
      guard_drive_type       d;
      int                    room_i;
      int                    hi_lim;
      int                    lo_lim;
      logic [TIMER_W+1:0]    tmo;
      room_i = $signed(c.room);
      tmo    = (TIMER_W + 2)'(cfg.switch_timeout);
      hi_lim = int'(cfg.setpoint) + int'(cfg.upper_band);
      lo_lim = int'(cfg.setpoint) - int'(cfg.lower_band);
      d.action = ACT_NONE;
      case (c.op)
         OP_TICK: begin
            if (since_ms != '1) since_ms = since_ms + 1'b1;
         end
         OP_CHECK: begin
            if (unit_on) begin
               if (cmp_running && start_ok && past_timeout(tmo << 2)
                   && (int'(start_room) - room_i) < int'(cfg.min_drop)) begin
                  cmp_running = 1'b0;
                  start_ok    = 1'b0;
                  since_ms    = '0;
                  bypass_on   = 1'b0;
                  d.action    = ACT_STOP_NOCOOL;
               end else if (!cmp_running && room_i > hi_lim && past_timeout(tmo)) begin
                  cmp_running = 1'b1;
                  start_room  = c.room;
                  start_ok    = 1'b1;
                  since_ms    = '0;
                  bypass_on   = 1'b0;
                  d.action    = ACT_STARTED;
               end else if (cmp_running && room_i <= lo_lim
                            && past_timeout((tmo + 1'b1) >> 1)) begin
                  cmp_running = 1'b0;
                  start_ok    = 1'b0;
                  since_ms    = '0;
                  bypass_on   = 1'b0;
                  d.action    = ACT_STOP_TARGET;
               end
            end
         end
         OP_START: begin
            unit_on  = 1'b1;
            since_ms = '0;
         end
         OP_STOP: begin
            unit_on     = 1'b0;
            cmp_running = 1'b0;
            since_ms    = '0;
         end
         OP_BYPASS: begin
            bypass_on = c.flag;
         end
         default: begin
         end
      endcase
      d.compressor = cmp_running;
      d.fan        = unit_on;
      return d;
   endfunction

   // request side: predict at each transfer, then present the next command
   always @(posedge clock) begin : req_driver
      guard_cmd_type cur;
      guard_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            cur.op   = req_tuser;
            cur.room = req_tdata[TEMP_W-1:0];
            cur.flag = req_tdata[TEMP_W];
            drive_q.push_back(guard_decide(cur));
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap = req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0) begin
               nxt = cmd_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= nxt.op;
               req_tdata  <= REQ_W'({nxt.flag, nxt.room});
               if (!no_idle && $urandom_range(0, 9) == 0) req_gap = $urandom_range(1, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_backpressure
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (rsp_gap != 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!no_idle && $urandom_range(0, 7) == 0) rsp_gap = $urandom_range(1, 5);
      end
   end

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_cnt++;
         if (mismatch_cnt <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      guard_drive_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
               $display("%0t: unexpected result transfer, data 0x%02h", $time, rsp_tdata);
         end else begin
            want = drive_q.pop_front();
            check_field("compressor_on", want.compressor, rsp_tdata[0]);
            check_field("fan_on", want.fan, rsp_tdata[1]);
            check_field("action", want.action, rsp_tdata[3:2]);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_cmd(input logic [OP_BITS-1:0] op, input int room, input logic flag);
      guard_cmd_type c;
      c.op   = op;
      c.room = TEMP_W'(room);
      c.flag = flag;
      cmd_q.push_back(c);
   endtask

   task automatic csr_write(input ctg_csr_type idx, input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SETPOINT:   cfg.setpoint       = val[SETPOINT_BITS-1:0];
         CSR_UPPER_BAND: cfg.upper_band     = val[BAND_BITS-1:0];
         CSR_LOWER_BAND: cfg.lower_band     = val[BAND_BITS-1:0];
         CSR_MIN_DROP:   cfg.min_drop       = val[BAND_BITS-1:0];
         CSR_TIMEOUT:    cfg.switch_timeout = val[TIMEOUT_BITS-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic apply_config(input int sp, input int ub, input int lb, input int md,
                               input int tmo);
      csr_write(CSR_SETPOINT, CSR_DATA_BITS'(sp));
      csr_write(CSR_UPPER_BAND, CSR_DATA_BITS'(ub));
      csr_write(CSR_LOWER_BAND, CSR_DATA_BITS'(lb));
      csr_write(CSR_MIN_DROP, CSR_DATA_BITS'(md));
      csr_write(CSR_TIMEOUT, CSR_DATA_BITS'(tmo));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (cmd_q.size() != 0 || req_tvalid || drive_q.size() != 0);
   endtask

   // aim at the start threshold, the stop threshold, the setpoint region or the minimum drop below the start threshold
   function automatic int pick_room();
      int hi_lim;
      int lo_lim;
      int r;
      hi_lim = int'(cfg.setpoint) + int'(cfg.upper_band);
      lo_lim = int'(cfg.setpoint) - int'(cfg.lower_band);
      case ($urandom_range(0, 3))
         0:       r = hi_lim - 1 + int'($urandom_range(0, 3));
         1:       r = lo_lim - 2 + int'($urandom_range(0, 3));
         2:       r = int'(cfg.setpoint) - 20 + int'($urandom_range(0, 40));
         default: r = hi_lim - int'(cfg.min_drop) - 2 + int'($urandom_range(0, 4));
      endcase
      if (r < TEMP_MIN) r = TEMP_MIN;
      if (r > TEMP_MAX) r = TEMP_MAX;
      return r;
   endfunction

   task automatic queue_random(input int n, input int bypass_pct);
      int count;
      int pick;
      int run;
      int tmo_cap;
      count   = 0;
      tmo_cap = (cfg.switch_timeout > 6) ? 6 : int'(cfg.switch_timeout);
      while (count < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            run = $urandom_range(1, 4 * tmo_cap + 3);
            repeat (run) add_cmd(OP_TICK, $urandom, 1'($urandom_range(0, 1)));
            count += run;
         end else if (pick < 62) begin
            add_cmd(OP_CHECK, pick_room(), 1'($urandom_range(0, 1)));
            count++;
         end else if (pick < 70) begin
            add_cmd(OP_START, $urandom, 1'($urandom_range(0, 1)));
            count++;
         end else if (pick < 75) begin
            add_cmd(OP_STOP, $urandom, 1'($urandom_range(0, 1)));
            count++;
         end else if (pick < 87) begin
            add_cmd(OP_BYPASS, $urandom, $urandom_range(0, 99) < bypass_pct);
            count++;
         end else if (pick < 92) begin
            // ignored opcodes: not counted
            add_cmd(OP_BITS'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), $urandom,
                    1'($urandom_range(0, 1)));
         end else begin
            add_cmd(OP_CHECK, $urandom, 1'($urandom_range(0, 1)));
            count++;
         end
      end
   endtask

   initial begin : stimulus
      int ph;
      cfg.setpoint       = SETPOINT_RST;
      cfg.upper_band     = UPPER_BAND_RST;
      cfg.lower_band     = LOWER_BAND_RST;
      cfg.min_drop       = MIN_DROP_RST;
      cfg.switch_timeout = TIMEOUT_RST;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: long timeout, so switching only through bypass
      add_cmd(OP_TICK, 0, 1'b0);
      add_cmd(OP_CHECK, TEMP_MAX, 1'b0);
      add_cmd(OP_UNUSED_LO, -1, 1'b1);
      add_cmd(OP_UNUSED_HI, TEMP_MIN, 1'b0);
      add_cmd(OP_START, 0, 1'b0);
      add_cmd(OP_CHECK, 990, 1'b0);
      add_cmd(OP_CHECK, TEMP_MAX, 1'b0);
      add_cmd(OP_BYPASS, 0, 1'b1);
      add_cmd(OP_CHECK, TEMP_MAX, 1'b0);
      add_cmd(OP_CHECK, TEMP_MIN, 1'b0);
      add_cmd(OP_BYPASS, 0, 1'b1);
      add_cmd(OP_CHECK, TEMP_MIN, 1'b0);
      add_cmd(OP_BYPASS, 0, 1'b1);
      add_cmd(OP_CHECK, 1006, 1'b0);
      add_cmd(OP_BYPASS, 0, 1'b1);
      add_cmd(OP_CHECK, 1005, 1'b0);
      add_cmd(OP_BYPASS, 0, 1'b1);
      add_cmd(OP_CHECK, 1005, 1'b0);
      add_cmd(OP_START, 0, 1'b0);
      add_cmd(OP_STOP, 0, 1'b0);
      add_cmd(OP_CHECK, TEMP_MAX, 1'b0);
      add_cmd(OP_BYPASS, 0, 1'b0);
      add_cmd(OP_START, 0, 1'b0);
      add_cmd(OP_TICK, 0, 1'b0);
      add_cmd(OP_CHECK, 0, 1'b0);
      drain();

      for (ph = 0; ph < PHASES; ph++) begin
         // hold both sides busy through the closing phase; the configuration
         // writes outlast any idle burst still running
         if (ph == PHASES - 1) no_idle = 1'b1;
         case (ph)
            0: apply_config(0, 0, 0, 0, 0);
            1: apply_config(1700, 255, 255, 255, 3);
            2: apply_config(2047, 0, 8, 4, 2);
            3: apply_config(1000, 15, 8, 4, 2);
            5: apply_config($urandom_range(0, 2047), $urandom_range(0, 20),
                            $urandom_range(0, 20), $urandom_range(0, 10), 16777215);
            default: apply_config($urandom_range(0, 2047), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 5));
         endcase
         queue_random(PHASE_ITEMS, (ph == 5) ? 80 : 30);
         drain();
      end

      repeat (6) @(posedge clock);
      if (mismatch_cnt == 0 && drive_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
